// ----- rtl/core/rcptdm_pkg.sv -----
package rcptdm_pkg;

    localparam int NUM_STICKS = 4;
    localparam int PULSE_W    = 12;
    localparam int OFFS_W     = 10;
    localparam int SCALE_W    = 7;
    localparam int DB_W       = 6;
    localparam int NUM_W      = 17;

    // stick lanes in input order: turn, throttle, lift, tilt
    localparam int LANE_TURN     = 0;
    localparam int LANE_THROTTLE = 1;
    localparam int LANE_LIFT     = 2;
    localparam int LANE_TILT     = 3;

    localparam int CAL_LO [NUM_STICKS] = '{1099, 1003, 993, 1023};
    localparam int CAL_HI [NUM_STICKS] = '{1978, 1986, 1885, 1986};

    localparam int SCALE_SPAN  = 126;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 18;

    localparam logic [PULSE_W-1:0] SWITCH_LEVEL = 12'd1500;
    localparam logic [SCALE_W-1:0] STOP_LEVEL   = 7'd64;
    localparam logic [DB_W-1:0]    DB_RESET     = 6'd30;

    typedef enum logic {
        CFG_LEFT_DB  = 1'b0,
        CFG_RIGHT_DB = 1'b1
    } cfg_addr_t;

endpackage

// ----- rtl/core/rc_pulse_tank_drive_mixer_core.sv -----
// Tank drive mixer for six receiver pulse widths. One transaction on s_ carries all six
// pulse widths; one transaction on m_ returns the motor, actuator and switch outputs. A new
// transaction is taken every clock cycle unless an m_tready stall has filled the stages,
// passing four register stages: pulse clamp, reciprocal multiply for the calibrated
// scaling, quotient correction, and dead zone plus arcade mix into the output register.
// Stalls on m_tready back up through the stages without losing or repeating anything.
// Deadband registers are to be written through cfg_wr_en/cfg_addr/cfg_wdata by the user
// only while no transaction is in flight; the block does not enforce this. Both reset to 30.
module rc_pulse_tank_drive_mixer_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  rcptdm_pkg::cfg_addr_t     cfg_addr,
    input  logic [rcptdm_pkg::DB_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // turn[11:0], throttle[23:12], lift[35:24], tilt[47:36], enable[59:48], lights[71:60]
    input  logic [71:0]               s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // left_drive[6:0], right_drive[13:7], tilt_drive[21:15], lift_drive[28:22], bits 14 and 29 tied high,
    // lights_on[30], drive_enable[31]
    output logic [31:0]               m_tdata
);
    import rcptdm_pkg::*;

    logic [DB_W-1:0] left_db_reg, left_db_next;
    logic [DB_W-1:0] right_db_reg, right_db_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [OFFS_W-1:0]  x1_reg [NUM_STICKS];
    logic [OFFS_W-1:0]  x1_next [NUM_STICKS];
    logic [OFFS_W-1:0]  x2_reg [NUM_STICKS];
    logic [SCALE_W-1:0] q2_reg [NUM_STICKS];
    logic [SCALE_W-1:0] q2_next [NUM_STICKS];
    logic [SCALE_W-1:0] s3_reg [NUM_STICKS];
    logic [SCALE_W-1:0] s3_next [NUM_STICKS];

    logic [1:0] sw1_reg, sw1_next, sw2_reg, sw3_reg;
    logic [31:0] m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------- configuration
    always_comb begin
        left_db_next  = left_db_reg;
        right_db_next = right_db_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LEFT_DB:  left_db_next  = cfg_wdata;
                CFG_RIGHT_DB: right_db_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_db_reg  <= DB_RESET;
            right_db_reg <= DB_RESET;
        end else begin
            left_db_reg  <= left_db_next;
            right_db_reg <= right_db_next;
        end
    end

    // ---------------------------------------------------------------- flow control
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign v1_next = rdy1 ? s_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // switches: bit 0 drive enable, bit 1 lights
    assign sw1_next = {s_tdata[71:60] > SWITCH_LEVEL, s_tdata[59:48] > SWITCH_LEVEL};

    always_ff @(posedge aclk) begin
        if (rdy1) sw1_reg <= sw1_next;
        if (rdy2) sw2_reg <= sw1_reg;
        if (rdy3) sw3_reg <= sw2_reg;
    end

    // ---------------------------------------------------------------- stick lanes
    for (genvar i = 0; i < NUM_STICKS; i++) begin : g_lane
        localparam int Lo  = CAL_LO[i];
        localparam int Hi  = CAL_HI[i];
        localparam int Div = Hi - Lo;
        localparam int Recip = (SCALE_SPAN * (2 ** RECIP_SHIFT)) / Div;
        localparam logic [PULSE_W-1:0] LO_V   = PULSE_W'(Lo);
        localparam logic [PULSE_W-1:0] HI_V   = PULSE_W'(Hi);
        localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(Recip);
        localparam logic [NUM_W-1:0]   DIV_V   = NUM_W'(Div);

        logic [PULSE_W-1:0] pulse, clamped;
        logic [OFFS_W+RECIP_W-1:0] prod;
        logic [NUM_W-1:0] num, qd, rem;
        logic inc;

        // stage 1: clamp to the calibrated range, take offset from the low end
        assign pulse = s_tdata[PULSE_W*i +: PULSE_W];
        always_comb begin
            clamped = pulse;
            if (pulse < LO_V) clamped = LO_V;
            else if (pulse > HI_V) clamped = HI_V;
        end
        assign x1_next[i] = OFFS_W'(clamped - LO_V);

        // stage 2: estimate offset*126/span by reciprocal, low by at most one
        assign prod       = (OFFS_W+RECIP_W)'(x1_reg[i]) * (OFFS_W+RECIP_W)'(RECIP_V);
        assign q2_next[i] = prod[RECIP_SHIFT +: SCALE_W];

        // stage 3: correct the estimate with the remainder, add one
        assign num  = NUM_W'({x2_reg[i], 7'd0}) - NUM_W'({x2_reg[i], 1'b0});
        assign qd   = NUM_W'(q2_reg[i]) * DIV_V;
        assign rem  = num - qd;
        assign inc  = rem >= DIV_V;
        assign s3_next[i] = q2_reg[i] + SCALE_W'(inc) + SCALE_W'(1);

        always_ff @(posedge aclk) begin
            if (rdy1) x1_reg[i] <= x1_next[i];
            if (rdy2) begin
                x2_reg[i] <= x1_reg[i];
                q2_reg[i] <= q2_next[i];
            end
            if (rdy3) s3_reg[i] <= s3_next[i];
        end
    end

    // ---------------------------------------------------------------- dead zone and mix
    logic [SCALE_W-1:0] dz [NUM_STICKS];
    logic [DB_W-1:0]    db [NUM_STICKS];

    assign db[LANE_TURN]     = right_db_reg;
    assign db[LANE_THROTTLE] = right_db_reg;
    assign db[LANE_LIFT]     = left_db_reg;
    assign db[LANE_TILT]     = left_db_reg;

    for (genvar j = 0; j < NUM_STICKS; j++) begin : g_dz
        logic [SCALE_W:0] upper, lower, val;
        assign val   = {1'b0, s3_reg[j]};
        assign upper = {1'b0, STOP_LEVEL} + (SCALE_W+1)'(db[j]);
        assign lower = {1'b0, STOP_LEVEL} - (SCALE_W+1)'(db[j]);
        assign dz[j] = (val < upper && val > lower) ? STOP_LEVEL : s3_reg[j];
    end

    logic signed [SCALE_W+1:0] turn_s, thr_s, mix_l, mix_r;
    logic [SCALE_W-1:0] left_cmd, right_cmd;

    assign turn_s = $signed({2'b00, dz[LANE_TURN]});
    assign thr_s  = $signed({2'b00, dz[LANE_THROTTLE]});
    assign mix_l  = thr_s + turn_s - $signed({2'b00, STOP_LEVEL});
    assign mix_r  = thr_s - turn_s + $signed({2'b00, STOP_LEVEL});

    always_comb begin
        if (mix_l < 9'sd1)        left_cmd = 7'd1;
        else if (mix_l > 9'sd127) left_cmd = 7'd127;
        else                      left_cmd = mix_l[SCALE_W-1:0];
        if (mix_r < 9'sd1)        right_cmd = 7'd1;
        else if (mix_r > 9'sd127) right_cmd = 7'd127;
        else                      right_cmd = mix_r[SCALE_W-1:0];
    end

    assign m_tdata_next = {sw3_reg[0], sw3_reg[1],
                           1'b1, dz[LANE_LIFT],
                           dz[LANE_TILT],
                           1'b1, right_cmd,
                           left_cmd};

    always_ff @(posedge aclk) begin
        if (rdy4) m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- assertions
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (q2_reg[0] <= 7'd126 && q2_reg[1] <= 7'd126 &&
                    q2_reg[2] <= 7'd126 && q2_reg[3] <= 7'd126))
        else $error("scaled quotient estimate out of range");

    a_scaled_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (s3_reg[0] != 7'd0 && s3_reg[1] != 7'd0 &&
                    s3_reg[2] != 7'd0 && s3_reg[3] != 7'd0))
        else $error("scaled stick value below one");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] != 7'd0 && m_tdata[14] && m_tdata[13:7] != 7'd0 &&
                      m_tdata[21:15] != 7'd0 && m_tdata[29] && m_tdata[28:22] != 7'd0))
        else $error("drive output outside its range");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4) |=> m_tvalid)
        else $error("stage three transaction lost");

endmodule
